// ===== src/xbm_pkg.sv =====
// ----------------------------------------------------------------------------
// xbm_pkg: shared types and constants
// Field widths, the sequencer states and the control and tag groups that
// travel between the top level and the rows of cells.
// ----------------------------------------------------------------------------
package xbm_pkg;

  localparam int unsigned VALUE_W = 61;
  localparam int unsigned SUM_W   = 62;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_SETTLE,
    ST_DRAIN,
    ST_TOKEN,
    ST_SEARCH
  } xbm_state_t;

  // Tag of a word moving down a row of cells.
  typedef struct packed {
    logic valid;
    logic greedy;   // 1: search token, 0: row to insert
  } item_tag_t;

  // Row-wide controls.
  typedef struct packed {
    logic shift;    // move every stored row one cell down
    logic clear;    // empty every cell at once
  } chain_ctrl_t;

endpackage

// ===== src/xbm_in_if.sv =====
// ----------------------------------------------------------------------------
// xbm_in_if: input channel
// Valid/ready channel carrying one set element and its end-of-set flag.
// ----------------------------------------------------------------------------
interface xbm_in_if;
  logic                        valid;
  logic                        ready;
  logic [xbm_pkg::VALUE_W-1:0] value;
  logic                        last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

// ===== src/xbm_out_if.sv =====
// ----------------------------------------------------------------------------
// xbm_out_if: result channel
// Valid/ready channel carrying one best split sum per set.
// ----------------------------------------------------------------------------
interface xbm_out_if;
  logic                      valid;
  logic                      ready;
  logic [xbm_pkg::SUM_W-1:0] best_sum;

  modport source (output valid, best_sum, input ready);
  modport sink   (input valid, best_sum, output ready);
endinterface

// ===== src/xor_basis_max_split_sum.sv =====
// ----------------------------------------------------------------------------
// xor_basis_max_split_sum: maximum split-XOR sum over a set of words
// Keeps a GF(2) basis of the set in a row of cells, then rebuilds it with
// the total's bits cleared and greedily searches it for the best sum.
// ----------------------------------------------------------------------------
// Throughput: one element word per cycle while a set streams in.
// Sequence: after the edge that accepts the word marked last, the insert row settles, is
//   drained into the rebuilt row, the search token passes through the rebuilt row and the
//   result register is loaded; in_ready stays low meanwhile, and longer while the token
//   waits for a free output register.
// Reset: synchronous active-low rst_n empties both rows, clears the running XOR and sequencer.
module xor_basis_max_split_sum #(
  parameter int unsigned WIDTH = 61
) (
  input logic        clk,
  input logic        rst_n,
  xbm_in_if.sink     in_ch,
  xbm_out_if.source  out_ch
);
  import xbm_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  xbm_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WIDTH-1:0]  rx_r, rx_nxt;          // running XOR of the set
  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_sum_r, out_sum_nxt;

  logic              in_accept;
  logic [WIDTH-1:0]  in_v;

  chain_ctrl_t       ctrl_a, ctrl_b;
  item_tag_t         tag_a_in, tag_b_in, tag_b_bot;
  logic [WIDTH-1:0]  v_b_in, v_b_bot, row_a_bot;
  logic              tok_arrive;

  assign in_accept = in_ch.valid && in_ch.ready;
  // bits at or above WIDTH are dropped; narrower fields are zero-extended
  assign in_v      = WIDTH'(in_ch.value);

  // --------------------------------------------------------------------------
  // Insert row: raw elements build the basis as they stream in
  // --------------------------------------------------------------------------
  assign tag_a_in = '{valid: in_accept, greedy: 1'b0};

  xbm_chain #(
    .WIDTH (WIDTH)
  ) u_chain_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl_a),
    .in_tag  (tag_a_in),
    .in_v    (in_v),
    .out_tag (),
    .out_v   (),
    .out_row (row_a_bot)
  );

  // --------------------------------------------------------------------------
  // Rebuild row: masked rows from the insert row, then the search token
  // --------------------------------------------------------------------------
  xbm_chain #(
    .WIDTH (WIDTH)
  ) u_chain_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl_b),
    .in_tag  (tag_b_in),
    .in_v    (v_b_in),
    .out_tag (tag_b_bot),
    .out_v   (v_b_bot),
    .out_row ()
  );

  // the token leaving the bottom carries the greatest masked subset XOR
  assign tok_arrive = tag_b_bot.valid && tag_b_bot.greedy;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_RUN: begin
        cnt_nxt = '0;
        if (in_accept && in_ch.last) begin
          state_nxt = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        // hold until the last word has left the insert row
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WIDTH)) begin
          state_nxt = ST_DRAIN;
          cnt_nxt   = '0;
        end
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WIDTH - 1)) begin
          state_nxt = ST_TOKEN;
          cnt_nxt   = '0;
        end
      end
      ST_TOKEN: begin
        // launch the token only when the output register is free
        if (!out_valid_r) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tok_arrive) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ch.ready  = 1'b0;
    ctrl_a       = '0;
    ctrl_b       = '0;
    tag_b_in     = '0;
    v_b_in       = '0;
    unique case (state_r)
      ST_RUN: begin
        in_ch.ready = 1'b1;
      end
      ST_SETTLE: begin
      end
      ST_DRAIN: begin
        // shift the insert row out; zeros refill it for the next set
        ctrl_a.shift = 1'b1;
        tag_b_in     = '{valid: 1'b1, greedy: 1'b0};
        v_b_in       = row_a_bot & ~rx_r;
      end
      ST_TOKEN: begin
        if (!out_valid_r) begin
          tag_b_in = '{valid: 1'b1, greedy: 1'b1};
        end
      end
      ST_SEARCH: begin
        ctrl_b.clear = tok_arrive;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Running XOR and result register
  // --------------------------------------------------------------------------
  always_comb begin
    rx_nxt        = rx_r;
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    if (in_accept) begin
      rx_nxt = rx_r ^ in_v;
    end
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (tok_arrive) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt   = SUM_W'({v_b_bot, 1'b0}) + SUM_W'(rx_r);
      rx_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      cnt_r       <= '0;
      rx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rx_r        <= rx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.best_sum = out_sum_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_tok_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_arrive |-> state_r == ST_SEARCH)
    else $error("search token left the row outside the search phase");

  a_tok_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    tok_arrive |-> !out_valid_r)
    else $error("search token arrived while a result word was pending");

  a_rx_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    tok_arrive |=> rx_r == '0)
    else $error("running XOR not cleared after a result");

  a_last_settles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_ch.last) |=> state_r == ST_SETTLE)
    else $error("last word did not start the settle phase");

endmodule

// ===== src/xbm_cell.sv =====
// ----------------------------------------------------------------------------
// xbm_cell: one basis row
// Holds the basis row whose leading bit is BIT and reduces, stores or
// searches with the word passing through it, or takes the row above on a shift.
// ----------------------------------------------------------------------------
module xbm_cell #(
  parameter int unsigned WIDTH = 61,
  parameter int unsigned BIT   = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  xbm_pkg::chain_ctrl_t ctrl,
  input  xbm_pkg::item_tag_t   tag_in,
  input  logic [WIDTH-1:0]     v_in,
  input  logic [WIDTH-1:0]     row_in,
  output xbm_pkg::item_tag_t   tag_out,
  output logic [WIDTH-1:0]     v_out,
  output logic [WIDTH-1:0]     row_out
);
  import xbm_pkg::*;

  logic [WIDTH-1:0] row_r, row_nxt;
  logic [WIDTH-1:0] v_r, v_nxt;
  item_tag_t        tag_r, tag_nxt;
  logic             occ;

  // A stored row has its leading bit set, except while rows are being shifted down.
  assign occ = row_r[BIT];

  always_comb begin
    row_nxt = row_r;
    v_nxt   = v_in;
    tag_nxt = tag_in;
    if (ctrl.clear) begin
      row_nxt       = '0;
      tag_nxt.valid = 1'b0;
    end else if (ctrl.shift) begin
      row_nxt = row_in;
    end else if (tag_in.valid) begin
      if (tag_in.greedy) begin
        // take the row when it raises this bit of the running best
        if (!v_in[BIT] && occ) begin
          v_nxt = v_in ^ row_r;
        end
      end else if (v_in[BIT]) begin
        if (occ) begin
          v_nxt = v_in ^ row_r;
        end else begin
          row_nxt = v_in;
          v_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      tag_r <= '0;
    end else begin
      row_r <= row_nxt;
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign tag_out = tag_r;
  assign v_out   = v_r;
  assign row_out = row_r;

endmodule

// ===== src/xbm_chain.sv =====
// ----------------------------------------------------------------------------
// xbm_chain: row of basis cells
// One cell per bit, top bit first; words step one cell down per cycle and
// stored rows can be shifted out at the bottom.
// ----------------------------------------------------------------------------
module xbm_chain #(
  parameter int unsigned WIDTH = 61
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  xbm_pkg::chain_ctrl_t ctrl,
  input  xbm_pkg::item_tag_t   in_tag,
  input  logic [WIDTH-1:0]     in_v,
  output xbm_pkg::item_tag_t   out_tag,
  output logic [WIDTH-1:0]     out_v,
  output logic [WIDTH-1:0]     out_row
);
  import xbm_pkg::*;

  // Index WIDTH is the top of the row, index 0 the bottom exit.
  item_tag_t        tag_w [WIDTH+1];
  logic [WIDTH-1:0] v_w   [WIDTH+1];
  logic [WIDTH-1:0] row_w [WIDTH+1];

  assign tag_w[WIDTH] = in_tag;
  assign v_w[WIDTH]   = in_v;
  assign row_w[WIDTH] = '0;

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    xbm_cell #(
      .WIDTH (WIDTH),
      .BIT   (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .tag_in  (tag_w[i+1]),
      .v_in    (v_w[i+1]),
      .row_in  (row_w[i+1]),
      .tag_out (tag_w[i]),
      .v_out   (v_w[i]),
      .row_out (row_w[i])
    );
  end

  assign out_tag = tag_w[0];
  assign out_v   = v_w[0];
  assign out_row = row_w[0];

endmodule
